FILE: hdl/edrm_pkg.sv
// Shared constants for the echo distance running median block.
package edrm_pkg;

    // Default length of the sample window.
    localparam int WINDOW_LEN_DEF = 50;

    // Field widths.
    localparam int ECHO_W = 16;
    localparam int CM_W   = 11;

    // floor(us * 17 / 1000) == (us * CM_RECIP) >> CM_SHIFT for every 16-bit us.
    // CM_RECIP = ceil(17 * 2^26 / 1000); the rounding error stays below one lsb.
    localparam int          RECIP_W  = 21;
    localparam int          CM_SHIFT = 26;
    localparam int          PROD_W   = ECHO_W + RECIP_W;
    localparam logic [RECIP_W-1:0] CM_RECIP = 21'd1140851;

endpackage

FILE: hdl/edrm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module edrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/echo_distance_running_median.sv
// Top level: running upper median of ultrasonic echo distances.
//
// Usage:
//   Input channel (i_echo_valid / o_echo_stall / i_echo_us): one echo pulse
//   width in microseconds per transfer. It is converted to centimeters as
//   floor(us * 17 / 1000) and replaces the oldest sample of a ring of
//   WINDOW_LEN samples.
//   Output channel (o_median_valid / i_median_stall / o_median_cm): one
//   transfer per input item, the upper median (rank WINDOW_LEN/2 of the
//   ascending window).
//   Throughput: a new input is taken only once the previous item's update
//   is finished, with o_echo_stall high meanwhile; the update is paced by
//   the two sweeps over the sorted-window RAM, one entry per cycle through
//   its single read port.
//   Reset: the window starts all zero. After reset a clearing pass writes
//   zero to every entry of both RAMs, with o_echo_stall high.
//   Receiver stall: the result sits in an output register; the next input
//   is still taken and processed, and only the final load of the following
//   result waits until the output register is free.
module echo_distance_running_median
    import edrm_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_echo_valid,
    output logic              o_echo_stall,
    input  logic [ECHO_W-1:0] i_echo_us,
    output logic              o_median_valid,
    input  logic              i_median_stall,
    output logic [CM_W-1:0]   o_median_cm
);

    localparam int AW = $clog2(WINDOW_LEN);
    localparam logic [AW-1:0] LAST = AW'(WINDOW_LEN - 1);
    localparam logic [AW-1:0] PEN  = AW'(WINDOW_LEN - 2);
    localparam logic [AW-1:0] MID  = AW'(WINDOW_LEN / 2);

    // Sequencer. The sorted RAM holds the window in ascending order.
    // REMOVE sweeps up, drops the first copy of the outgoing sample and
    // shifts the rest down one place; INSERT sweeps down from the top,
    // shifting larger samples up until the new sample fits.
    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_REMOVE = 8'b0000_1000,
        S_TURN   = 8'b0001_0000,
        S_INSERT = 8'b0010_0000,
        S_LAST   = 8'b0100_0000,
        S_MEDIAN = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_idx, n_idx;
    logic [CM_W-1:0] r_new, n_new;
    logic [CM_W-1:0] r_old, n_old;
    logic            r_found, n_found;
    logic            r_done, n_done;
    logic            r_out_valid, n_out_valid;
    logic [CM_W-1:0] r_out_cm, n_out_cm;

    logic [AW-1:0]     idx_next;
    logic [PROD_W-1:0] cm_prod;

    // Ring RAM: sample by arrival slot. Sorted RAM: same samples, ranked.
    logic            ring_wr_en;
    logic [AW-1:0]   ring_wr_addr;
    logic [CM_W-1:0] ring_wr_data;
    logic [AW-1:0]   ring_rd_addr;
    logic [CM_W-1:0] ring_rd_data;
    logic            srt_wr_en;
    logic [AW-1:0]   srt_wr_addr;
    logic [CM_W-1:0] srt_wr_data;
    logic [AW-1:0]   srt_rd_addr;
    logic [CM_W-1:0] srt_rd_data;

    edrm_ram #(
        .WIDTH (CM_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ring_wr_en),
        .i_wr_addr (ring_wr_addr),
        .i_wr_data (ring_wr_data),
        .i_rd_addr (ring_rd_addr),
        .o_rd_data (ring_rd_data)
    );

    edrm_ram #(
        .WIDTH (CM_W),
        .DEPTH (WINDOW_LEN)
    ) u_sort_ram (
        .i_clk     (i_clk),
        .i_wr_en   (srt_wr_en),
        .i_wr_addr (srt_wr_addr),
        .i_wr_data (srt_wr_data),
        .i_rd_addr (srt_rd_addr),
        .o_rd_data (srt_rd_data)
    );

    // Ring pointer advances before the write.
    assign idx_next = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    // Microseconds to centimeters by reciprocal multiply; registered into r_new.
    assign cm_prod = PROD_W'(i_echo_us) * PROD_W'(CM_RECIP);

    assign o_echo_stall   = (r_state != S_IDLE);
    assign o_median_valid = r_out_valid;
    assign o_median_cm    = r_out_cm;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_new       = r_new;
        n_old       = r_old;
        n_found     = r_found;
        n_done      = r_done;
        n_out_valid = r_out_valid;
        n_out_cm    = r_out_cm;

        ring_wr_en   = 1'b0;
        ring_wr_addr = r_idx;
        ring_wr_data = r_new;
        ring_rd_addr = idx_next;   // old sample of the slot about to be reused
        srt_wr_en    = 1'b0;
        srt_wr_addr  = r_cnt;
        srt_wr_data  = srt_rd_data;
        srt_rd_addr  = MID;

        // Output transfer frees the register.
        if (r_out_valid && !i_median_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ring_wr_en   = 1'b1;
                ring_wr_addr = r_cnt;
                ring_wr_data = '0;
                srt_wr_en    = 1'b1;
                srt_wr_addr  = r_cnt;
                srt_wr_data  = '0;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_echo_valid) begin
                    n_idx   = idx_next;
                    n_new   = cm_prod[CM_SHIFT +: CM_W];
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // Outgoing sample is on the ring read port; overwrite its slot.
                n_old       = ring_rd_data;
                ring_wr_en  = 1'b1;
                srt_rd_addr = '0;
                n_cnt       = '0;
                n_found     = 1'b0;
                n_done      = 1'b0;
                n_state     = S_REMOVE;
            end
            S_REMOVE: begin
                // srt_rd_data is entry r_cnt
                if (!r_found) begin
                    if (srt_rd_data == r_old) begin
                        n_found = 1'b1;
                    end
                end else begin
                    srt_wr_en   = 1'b1;
                    srt_wr_addr = r_cnt - 1'b1;
                    srt_wr_data = srt_rd_data;
                end
                if (r_cnt == LAST) begin
                    n_state = S_TURN;
                end else begin
                    srt_rd_addr = r_cnt + 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                end
            end
            S_TURN: begin
                // Read of the next-to-last entry waits for its last write.
                srt_rd_addr = PEN;
                n_cnt       = PEN;
                n_state     = S_INSERT;
            end
            S_INSERT: begin
                // srt_rd_data is entry r_cnt; the free slot is r_cnt + 1
                if (!r_done) begin
                    srt_wr_en   = 1'b1;
                    srt_wr_addr = r_cnt + 1'b1;
                    if (srt_rd_data > r_new) begin
                        srt_wr_data = srt_rd_data;
                    end else begin
                        srt_wr_data = r_new;
                        n_done      = 1'b1;
                    end
                end
                if (r_cnt == '0) begin
                    n_state = S_LAST;
                end else begin
                    srt_rd_addr = r_cnt - 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                end
            end
            S_LAST: begin
                // New sample is the smallest: it takes entry 0.
                if (!r_done) begin
                    srt_wr_en   = 1'b1;
                    srt_wr_addr = '0;
                    srt_wr_data = r_new;
                end
                srt_rd_addr = MID;
                n_state     = S_MEDIAN;
            end
            S_MEDIAN: begin
                srt_rd_addr = MID;
                if (!r_out_valid || !i_median_stall) begin
                    n_out_valid = 1'b1;
                    n_out_cm    = srt_rd_data;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
        r_new    <= n_new;
        r_old    <= n_old;
        r_out_cm <= n_out_cm;
    end

    // The outgoing sample must be present in the sorted window.
    a_old_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE && r_cnt == LAST) |-> (r_found || srt_rd_data == r_old))
        else $error("outgoing sample missing from sorted window");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_echo_valid && !o_echo_stall) |=> (r_state == S_READ && r_idx == $past(idx_next)))
        else $error("input transfer did not start an update");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_idx} < (AW + 1)'(WINDOW_LEN))
        else $error("ring index out of range");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_MEDIAN)
        else $error("result raised outside median read");

endmodule

FILE: sim/tb_echo_distance_running_median.sv
// Testbench for echo_distance_running_median: directed and random echo widths, scoreboard check.
module tb_echo_distance_running_median
    import edrm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_LEN   = WINDOW_LEN_DEF;
    localparam int CM_MUL       = 17;
    localparam int CM_DIV       = 1000;
    localparam int RANDOM_ITEMS = 1125;
    localparam int IDLE_LIMIT   = 4000;          // cycles with no transfer on either side
    localparam int SETTLE_WAIT  = 2 * WINDOW_LEN + 10;

    // Random stimulus flavors, one per block of items.
    typedef enum int {
        FLV_UNIFORM,
        FLV_CLUSTER,
        FLV_NEAR_MAX,
        FLV_ZEROS,
        FLV_RAMP,
        FLV_TIES,
        FLV_COUNT
    } t_flavor;

    // Tracks the sample ring and the medians still to come out of the block.
    class t_median_scoreboard;
        logic [CM_W-1:0] ring [WINDOW_LEN];
        int unsigned     wr_idx;
        logic [CM_W-1:0] pending_medians [$];
        int unsigned     errors;
        int unsigned     echoes_taken;
        int unsigned     medians_checked;

        function new();
            foreach (ring[k]) ring[k] = '0;
            wr_idx          = 0;
            errors          = 0;
            echoes_taken    = 0;
            medians_checked = 0;
        endfunction

        function logic [CM_W-1:0] us_to_cm(logic [ECHO_W-1:0] us);
            int unsigned prod;
            prod = us;
            prod = prod * CM_MUL / CM_DIV;
            return prod[CM_W-1:0];
        endfunction

        // Rank WINDOW_LEN/2 of the ascending window.
        function logic [CM_W-1:0] window_median();
            logic [CM_W-1:0] sorted [WINDOW_LEN];
            logic [CM_W-1:0] v;
            int j;
            sorted = ring;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                v = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            return sorted[WINDOW_LEN/2];
        endfunction

        // Index moves first, so the first sample after reset goes to entry 1.
        function void note_echo(logic [ECHO_W-1:0] us);
            wr_idx = wr_idx + 1;
            if (wr_idx >= WINDOW_LEN) wr_idx = 0;
            ring[wr_idx] = us_to_cm(us);
            pending_medians.push_back(window_median());
            echoes_taken++;
        endfunction

        function void check_median(logic [CM_W-1:0] cm);
            logic [CM_W-1:0] want;
            medians_checked++;
            if (pending_medians.size() == 0) begin
                $display("%0t: median transfer with none pending, actual %0d", $time, cm);
                errors++;
            end else begin
                want = pending_medians.pop_front();
                if (cm !== want) begin
                    $display("%0t: median_cm mismatch, expected %0d actual %0d",
                             $time, want, cm);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return pending_medians.size();
        endfunction
    endclass

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_echo_valid   = 1'b0;
    logic              o_echo_stall;
    logic [ECHO_W-1:0] i_echo_us      = '0;
    logic              o_median_valid;
    logic              i_median_stall = 1'b0;
    logic [CM_W-1:0]   o_median_cm;

    t_median_scoreboard sb = new();
    int unsigned        idle_cycles = 0;

    logic [ECHO_W-1:0] directed_us [25] = '{
        16'd0, 16'd65535, 16'd1, 16'd58, 16'd59, 16'd117, 16'd118, 16'd999,
        16'd1000, 16'd1001, 16'd32767, 16'd32768, 16'd58823, 16'd58824, 16'd65534,
        16'd21845, 16'd43690, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
        16'd65535, 16'd65535, 16'd65535, 16'd65535
    };

    echo_distance_running_median #(
        .WINDOW_LEN(WINDOW_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_echo_valid   (i_echo_valid),
        .o_echo_stall   (o_echo_stall),
        .i_echo_us      (i_echo_us),
        .o_median_valid (o_median_valid),
        .i_median_stall (i_median_stall),
        .o_median_cm    (o_median_cm)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly short, now and then long.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(1, 3);
        if (r < 90) return $urandom_range(4, 60);
        return $urandom_range(100, 400);
    endfunction

    // Monitor: values read here are the ones the edge acted on.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_echo_valid && !o_echo_stall) sb.note_echo(i_echo_us);
            if (o_median_valid && !i_median_stall) sb.check_median(o_median_cm);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_echo_valid && !o_echo_stall) || (o_median_valid && !i_median_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d medians outstanding",
                     $time, IDLE_LIMIT, sb.pending());
            $display("[echo_distance_running_median] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, with long open stretches now and then.
    initial begin : median_sink
        int run;
        forever begin
            @(posedge i_clk);
            i_median_stall <= 1'b0;
            if ($urandom_range(0, 15) == 0) run = $urandom_range(300, 1500);
            else run = $urandom_range(1, 120);
            repeat (run) @(posedge i_clk);
            i_median_stall <= 1'b1;
            repeat (pick_idle_len() - 1) @(posedge i_clk);
        end
    end

    // One echo transfer; optional idle gap ahead of it. Returns at the accepting edge.
    task automatic send_echo(input logic [ECHO_W-1:0] us, input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap && $urandom_range(0, 1)) gap = pick_idle_len();
        if (gap > 0) begin
            i_echo_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_echo_valid <= 1'b1;
        i_echo_us    <= us;
        do @(posedge i_clk); while (o_echo_stall);
    endtask

    // Hold the sender off until every pending median has come out.
    task automatic drain_medians();
        i_echo_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ECHO_W-1:0] pick_echo(t_flavor flv, int unsigned center,
                                                    int unsigned step, int unsigned seq);
        int unsigned v;
        case (flv)
            FLV_UNIFORM:  v = $urandom_range(0, 65535);
            FLV_CLUSTER: begin
                v = center + $urandom_range(0, 600);
                if (v > 300) v = v - 300;
                if (v > 65535) v = 65535;
            end
            FLV_NEAR_MAX: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                          : 65535 - $urandom_range(0, 60);
            FLV_ZEROS:    v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 58);
            FLV_RAMP:     v = (center + seq * step) % 65536;
            default:      v = center + 59 * $urandom_range(0, 3);   // few distinct values
        endcase
        if (v > 65535) v = 65535;
        return v[ECHO_W-1:0];
    endfunction

    initial begin : stimulus
        t_flavor     flv;
        int unsigned center, step, blk_len, seq, sent;
        bit          gaps_on;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty window, conversion boundaries, largest input, duplicates.
        foreach (directed_us[k]) send_echo(directed_us[k], 1'b1);
        drain_medians();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            flv     = t_flavor'($urandom_range(0, FLV_COUNT - 1));
            center  = $urandom_range(0, 65535);
            step    = $urandom_range(1, 2000);
            blk_len = $urandom_range(20, 80);
            gaps_on = ($urandom_range(0, 4) != 0);
            for (seq = 0; seq < blk_len && sent < RANDOM_ITEMS; seq++) begin
                send_echo(pick_echo(flv, center, step, seq), gaps_on);
                sent++;
                if (sent == RANDOM_ITEMS / 2) drain_medians();
            end
        end
        i_echo_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Run covered %0d echo samples and %0d checked medians (%0d window wraps),",
                 sb.echoes_taken, sb.medians_checked, sb.echoes_taken / WINDOW_LEN);
        $display("with uniform, clustered, ramp, tied and extreme-value stretches.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[echo_distance_running_median] OK");
        end else begin
            $display("[echo_distance_running_median] ERROR");
        end
        $finish;
    end

endmodule

FILE: echo_distance_running_median.f
hdl/edrm_pkg.sv
hdl/edrm_ram.sv
hdl/echo_distance_running_median.sv
sim/tb_echo_distance_running_median.sv
